@@ design/ols_pkg.sv @@
// Shared types and codes for the ordered list / stack engine.
`default_nettype none

package ols_pkg;

    localparam int OP_W     = 3;
    localparam int STATUS_W = 2;

    typedef enum logic [OP_W-1:0] {
        OP_APPEND     = 3'd0,
        OP_INSERT     = 3'd1,
        OP_GET        = 3'd2,
        OP_SET        = 3'd3,
        OP_FIND       = 3'd4,
        OP_REMOVE_VAL = 3'd5,
        OP_REMOVE_AT  = 3'd6,
        OP_CLEAR      = 3'd7
    } ols_op_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK     = 2'd0,
        STATUS_RANGE  = 2'd1,
        STATUS_FULL   = 2'd2,
        STATUS_ABSENT = 2'd3
    } ols_status_t;

    // Per-cycle command broadcast along the cell row.
    typedef enum logic [1:0] {
        ACT_NONE   = 2'd0,
        ACT_INSERT = 2'd1,
        ACT_WRITE  = 2'd2,
        ACT_REMOVE = 2'd3
    } ols_act_t;

    typedef enum logic [1:0] {
        ST_IDLE   = 2'd0,
        ST_SEARCH = 2'd1,
        ST_COMMIT = 2'd2
    } ols_state_t;

endpackage

`default_nettype wire

@@ design/ols_cell.sv @@
// One list cell: holds one element, shifts toward either neighbor, compares for search.
`default_nettype none

module ols_cell
    import ols_pkg::*;
#(
    parameter int WIDTH = 32,
    parameter int IDX_W = 6,
    parameter int CNT_W = 7,
    parameter int INDEX = 0
) (
    input  wire logic             aclk,
    input  wire ols_act_t         act,
    input  wire logic [IDX_W-1:0] tgt,
    input  wire logic [WIDTH-1:0] wr_value,
    input  wire logic [WIDTH-1:0] left_data,
    input  wire logic [WIDTH-1:0] right_data,
    input  wire logic [WIDTH-1:0] cmp_value,
    input  wire logic [CNT_W-1:0] count,
    output logic      [WIDTH-1:0] data,
    output logic                  hit
);

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);
    localparam logic [CNT_W-1:0] MY_CNT = CNT_W'(INDEX);

    logic [WIDTH-1:0] data_reg;
    logic [WIDTH-1:0] data_next;

    always_comb begin
        data_next = data_reg;
        unique case (act)
            ACT_INSERT: begin
                if (MY_IDX > tgt) begin
                    data_next = left_data;
                end else if (MY_IDX == tgt) begin
                    data_next = wr_value;
                end
            end
            ACT_WRITE: begin
                if (MY_IDX == tgt) begin
                    data_next = wr_value;
                end
            end
            ACT_REMOVE: begin
                if (MY_IDX >= tgt) begin
                    data_next = right_data;
                end
            end
            ACT_NONE: begin
                data_next = data_reg;
            end
            default: begin
                data_next = data_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign data = data_reg;
    // only occupied cells take part in a search
    assign hit  = (data_reg == cmp_value) && (MY_CNT < count);

endmodule

`default_nettype wire

@@ design/ols_prio.sv @@
// First-hit encoder over the registered cell match vector.
`default_nettype none

module ols_prio
    import ols_pkg::*;
#(
    parameter int DEPTH = 64,
    parameter int IDX_W = 6
) (
    input  wire logic [DEPTH-1:0] hits,
    output logic                  found,
    output logic      [IDX_W-1:0] first_idx
);

    always_comb begin
        first_idx = '0;
        for (int i = DEPTH - 1; i >= 0; i--) begin
            if (hits[i]) begin
                first_idx = IDX_W'(i);
            end
        end
    end

    assign found = |hits;

endmodule

`default_nettype wire

@@ design/ordered_list_stack_engine.sv @@
// Ordered list / stack engine top level: request FSM, cell row, first-hit encoder.
// A request passes the search state, then the commit state, where the result is registered.
// One request at a time: a new one is taken only back in idle; the search state registers the match vector
//   between the cell compare and the first-hit encode, and the commit state shifts the cells.
// Commit waits while the result register is still full and not taken.
// Reset (aresetn low, synchronous): FSM idle, element count zero, no result pending;
//   cell contents are not cleared and only occupied cells are ever read.
`default_nettype none

module ordered_list_stack_engine
    import ols_pkg::*;
#(
    parameter int DEPTH = 64,
    parameter int WIDTH = 32
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    // request channel
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    // s_tdata: operation, position, value (from bit 0), zero padded to bytes
    input  wire logic [((OP_W+$clog2(DEPTH+1)+WIDTH+7)/8)*8-1:0] s_tdata,
    // result channel
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    // m_tdata: read_value, found_index, status, length (from bit 0), zero padded
    output logic [((WIDTH+$clog2(DEPTH)+STATUS_W+$clog2(DEPTH+1)+7)/8)*8-1:0] m_tdata
);

    localparam int IDX_W    = $clog2(DEPTH);
    localparam int CNT_W    = $clog2(DEPTH + 1);
    localparam int OUT_BITS = WIDTH + IDX_W + STATUS_W + CNT_W;
    localparam int OUT_TW   = ((OUT_BITS + 7) / 8) * 8;
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    // ---------------------------------------------------------------
    // Control state
    // ---------------------------------------------------------------
    ols_state_t       state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             m_tvalid_reg;

    // captured request
    ols_op_t          op_reg;
    logic [CNT_W-1:0] pos_reg;
    logic [WIDTH-1:0] val_reg;

    // match vector from the cell row, registered in the search cycle
    logic [DEPTH-1:0] cell_hit;
    logic [DEPTH-1:0] hits_reg;
    logic [WIDTH-1:0] cell_data [DEPTH];

    // result register
    logic [OUT_BITS-1:0] result_reg;

    logic             s_fire;
    logic             commit;
    logic             found;
    logic [IDX_W-1:0] first_idx;

    // commit decode
    ols_act_t         act;
    ols_act_t         cell_act;
    logic [IDX_W-1:0] tgt;
    logic             rd_en;
    ols_status_t      status;
    logic [IDX_W-1:0] fidx_out;
    logic [WIDTH-1:0] rd_out;
    logic             pos_lt_cnt;
    logic             pos_le_cnt;
    logic             full;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_fire   = s_tvalid && s_tready;
    // commit only when the result slot is free or drains this cycle
    assign commit   = (state_reg == ST_COMMIT) && (!m_tvalid_reg || m_tready);

    // ---------------------------------------------------------------
    // FSM
    // ---------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    state_next = ST_SEARCH;
                end
            end
            ST_SEARCH: begin
                state_next = ST_COMMIT;
            end
            ST_COMMIT: begin
                if (commit) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // request capture
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            op_reg  <= ols_op_t'(s_tdata[OP_W-1:0]);
            pos_reg <= s_tdata[OP_W +: CNT_W];
            val_reg <= s_tdata[OP_W+CNT_W +: WIDTH];
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_SEARCH) begin
            hits_reg <= cell_hit;
        end
    end

    // ---------------------------------------------------------------
    // Cell row
    // ---------------------------------------------------------------
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic [WIDTH-1:0] left_data;
        logic [WIDTH-1:0] right_data;

        if (i == 0) begin : g_first
            assign left_data = val_reg;
        end else begin : g_mid_l
            assign left_data = cell_data[i-1];
        end

        if (i == DEPTH - 1) begin : g_last
            assign right_data = cell_data[i];
        end else begin : g_mid_r
            assign right_data = cell_data[i+1];
        end

        ols_cell #(
            .WIDTH (WIDTH),
            .IDX_W (IDX_W),
            .CNT_W (CNT_W),
            .INDEX (i)
        ) u_cell (
            .aclk       (aclk),
            .act        (cell_act),
            .tgt        (tgt),
            .wr_value   (val_reg),
            .left_data  (left_data),
            .right_data (right_data),
            .cmp_value  (val_reg),
            .count      (count_reg),
            .data       (cell_data[i]),
            .hit        (cell_hit[i])
        );
    end

    ols_prio #(
        .DEPTH (DEPTH),
        .IDX_W (IDX_W)
    ) u_prio (
        .hits      (hits_reg),
        .found     (found),
        .first_idx (first_idx)
    );

    // ---------------------------------------------------------------
    // Commit decode: status, target cell, shift direction, new count
    // ---------------------------------------------------------------
    assign pos_lt_cnt = (pos_reg < count_reg);
    assign pos_le_cnt = (pos_reg <= count_reg);
    assign full       = (count_reg == FULL_CNT);

    always_comb begin
        act        = ACT_NONE;
        tgt        = '0;
        rd_en      = 1'b0;
        status     = STATUS_OK;
        fidx_out   = '0;
        count_next = count_reg;
        unique case (op_reg)
            OP_APPEND: begin
                if (full) begin
                    status = STATUS_FULL;
                end else begin
                    act        = ACT_INSERT;
                    tgt        = count_reg[IDX_W-1:0];
                    count_next = count_reg + CNT_W'(1);
                end
            end
            OP_INSERT: begin
                // range check comes before the full check
                if (!pos_le_cnt) begin
                    status = STATUS_RANGE;
                end else if (full) begin
                    status = STATUS_FULL;
                end else begin
                    act        = ACT_INSERT;
                    tgt        = pos_reg[IDX_W-1:0];
                    count_next = count_reg + CNT_W'(1);
                end
            end
            OP_GET: begin
                if (!pos_lt_cnt) begin
                    status = STATUS_RANGE;
                end else begin
                    tgt   = pos_reg[IDX_W-1:0];
                    rd_en = 1'b1;
                end
            end
            OP_SET: begin
                if (!pos_lt_cnt) begin
                    status = STATUS_RANGE;
                end else begin
                    act = ACT_WRITE;
                    tgt = pos_reg[IDX_W-1:0];
                end
            end
            OP_FIND: begin
                if (!found) begin
                    status = STATUS_ABSENT;
                end else begin
                    fidx_out = first_idx;
                end
            end
            OP_REMOVE_VAL: begin
                if (!found) begin
                    status = STATUS_ABSENT;
                end else begin
                    act        = ACT_REMOVE;
                    tgt        = first_idx;
                    rd_en      = 1'b1;
                    fidx_out   = first_idx;
                    count_next = count_reg - CNT_W'(1);
                end
            end
            OP_REMOVE_AT: begin
                if (!pos_lt_cnt) begin
                    status = STATUS_RANGE;
                end else begin
                    act        = ACT_REMOVE;
                    tgt        = pos_reg[IDX_W-1:0];
                    rd_en      = 1'b1;
                    count_next = count_reg - CNT_W'(1);
                end
            end
            OP_CLEAR: begin
                count_next = '0;
            end
            default: begin
                count_next = count_reg;
            end
        endcase
    end

    // cells only move on the commit cycle
    assign cell_act = commit ? act : ACT_NONE;
    // read path: value of the target cell before it shifts
    assign rd_out   = rd_en ? cell_data[tgt] : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (commit) begin
            count_reg <= count_next;
        end
    end

    // ---------------------------------------------------------------
    // Result register
    // ---------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (commit) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (commit) begin
            result_reg <= {count_next, status, fidx_out, rd_out};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = OUT_TW'(result_reg);

endmodule

`default_nettype wire
